// ===== sv/sbr_pkg.sv =====
// Shared constants, types and state encoding for the stream byte reassembler.
package sbr_pkg;

    localparam int CAPACITY   = 64;
    localparam int RING_DEPTH = 64;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 32;
    localparam int BYTE_W     = 8;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              stream_end;
        logic              last;
    } result_t;

endpackage

// ===== sv/stream_byte_reassembler.sv =====
// Top level: out-of-order byte stream reassembler with ring store and in-order drain.
// Each input item carries at most one byte and its absolute stream index. A byte is kept
// when its index lies in [next index, min(read total, next index) + CAPACITY); it goes to
// the ring slot index mod 64, and a byte already held in that slot wins over a duplicate.
// Bytes are delivered strictly in order as soon as the byte at the next index is present,
// one item per byte; last marks the final item an input caused, and stream_end is set on
// it when eof has been seen and nothing stays pending. With eof seen, nothing pending and
// no byte to deliver, one item with out_valid low and stream_end high is sent. After the
// end of stream, input items are still taken but ignored. Timing: an input item is taken
// in ST_IDLE; in the next cycle the block checks the slot at the next index, and that
// check shares its cycle with the first read, so contiguous bytes drain at one per cycle
// through the single read port of the ring RAM (registered read) while the result
// channel keeps up; after the last read, ST_FLUSH waits until the final byte has moved
// to the output register. No new input item is taken before the block is back in
// ST_IDLE. Slot valid marks are flip-flops cleared by reset, so the block is ready right
// after reset with no clearing pass.
module stream_byte_reassembler (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_has_byte,
    input  logic [sbr_pkg::IDX_W-1:0]   s_stream_index,
    input  logic [sbr_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                        s_eof,
    input  logic [sbr_pkg::IDX_W-1:0]   s_consumer_read_total,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sbr_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_out_valid,
    output logic                        m_stream_end,
    output logic                        m_last
);

    // control state
    sbr_pkg::state_t                  state_reg, state_next;
    logic [sbr_pkg::RING_DEPTH-1:0]   valid_reg, valid_next;
    logic [sbr_pkg::IDX_W-1:0]        next_index_reg, next_index_next;
    logic [sbr_pkg::CNT_W-1:0]        pending_reg, pending_next;
    logic                             eof_reg, eof_next;
    logic                             done_reg, done_next;
    // read in flight / RAM data waiting for the output register
    logic                             hold_reg, hold_next;
    logic                             hold_last_reg, hold_last_next;
    logic                             hold_end_reg, hold_end_next;

    logic                             accept;
    logic [sbr_pkg::IDX_W-1:0]        rd_clamped;
    logic [sbr_pkg::IDX_W:0]          limit;
    logic                             in_window;
    logic [sbr_pkg::SLOT_W-1:0]       wr_slot;
    logic                             ram_we;
    logic [sbr_pkg::SLOT_W-1:0]       cur_slot;
    logic [sbr_pkg::SLOT_W-1:0]       succ_slot;
    logic                             ram_re;
    logic [sbr_pkg::BYTE_W-1:0]       ram_rd_data;
    logic                             out_free;
    logic                             move;
    logic                             can_issue;
    logic                             empty_load;
    logic                             out_load;
    sbr_pkg::result_t                 out_data;
    logic                             issue_last;

    assign s_ready = (state_reg == sbr_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // window check: read total clamped to next index, bound computed one bit wider
    assign rd_clamped = (s_consumer_read_total > next_index_reg) ? next_index_reg
                                                                 : s_consumer_read_total;
    assign limit      = {1'b0, rd_clamped} + (sbr_pkg::IDX_W+1)'(sbr_pkg::CAPACITY);
    assign in_window  = (s_stream_index >= next_index_reg)
                     && ({1'b0, s_stream_index} < limit);
    assign wr_slot    = s_stream_index[sbr_pkg::SLOT_W-1:0];
    assign ram_we     = accept && !done_reg && s_has_byte && in_window && !valid_reg[wr_slot];

    assign cur_slot   = next_index_reg[sbr_pkg::SLOT_W-1:0];
    assign succ_slot  = cur_slot + sbr_pkg::SLOT_W'(1);

    assign move       = hold_reg && out_free;
    assign can_issue  = !hold_reg || move;
    assign issue_last = !valid_reg[succ_slot];

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        next_index_next = next_index_reg;
        pending_next    = pending_reg;
        eof_next        = eof_reg;
        done_next       = done_reg;
        hold_next       = hold_reg;
        hold_last_next  = hold_last_reg;
        hold_end_next   = hold_end_reg;
        ram_re          = 1'b0;
        empty_load      = 1'b0;

        if (move) begin
            hold_next = 1'b0;
        end

        case (state_reg)
            sbr_pkg::ST_IDLE: begin
                if (accept && !done_reg) begin
                    if (ram_we) begin
                        valid_next[wr_slot] = 1'b1;
                        pending_next        = pending_reg + sbr_pkg::CNT_W'(1);
                    end
                    if (s_eof) begin
                        eof_next = 1'b1;
                    end
                    state_next = sbr_pkg::ST_DRAIN;
                end
            end
            sbr_pkg::ST_DRAIN: begin
                if (valid_reg[cur_slot]) begin
                    if (can_issue) begin
                        ram_re               = 1'b1;
                        valid_next[cur_slot] = 1'b0;
                        pending_next         = pending_reg - sbr_pkg::CNT_W'(1);
                        next_index_next      = next_index_reg + sbr_pkg::IDX_W'(1);
                        hold_next            = 1'b1;
                        hold_last_next       = issue_last;
                        hold_end_next        = issue_last && eof_reg
                                            && (pending_reg == sbr_pkg::CNT_W'(1));
                        if (issue_last) begin
                            if (eof_reg && (pending_reg == sbr_pkg::CNT_W'(1))) begin
                                done_next = 1'b1;
                            end
                            state_next = sbr_pkg::ST_FLUSH;
                        end
                    end
                end else if (eof_reg && (pending_reg == '0)) begin
                    // end of stream with no byte to deliver: a lone end marker
                    if (out_free) begin
                        empty_load = 1'b1;
                        done_next  = 1'b1;
                        state_next = sbr_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = sbr_pkg::ST_IDLE;
                end
            end
            sbr_pkg::ST_FLUSH: begin
                if (!hold_reg || move) begin
                    state_next = sbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbr_pkg::ST_IDLE;
            valid_reg      <= '0;
            next_index_reg <= '0;
            pending_reg    <= '0;
            eof_reg        <= 1'b0;
            done_reg       <= 1'b0;
            hold_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            next_index_reg <= next_index_next;
            pending_reg    <= pending_next;
            eof_reg        <= eof_next;
            done_reg       <= done_next;
            hold_reg       <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_last_reg <= hold_last_next;
        hold_end_reg  <= hold_end_next;
    end

    // ring byte store
    sbr_ram #(
        .WIDTH (sbr_pkg::BYTE_W),
        .DEPTH (sbr_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_slot),
        .wr_data (s_data_byte),
        .rd_en   (ram_re),
        .rd_addr (cur_slot),
        .rd_data (ram_rd_data)
    );

    // result item: RAM byte in flight, or the lone end marker
    assign out_load = move || empty_load;
    always_comb begin
        if (move) begin
            out_data.out_byte   = ram_rd_data;
            out_data.out_valid  = 1'b1;
            out_data.stream_end = hold_end_reg;
            out_data.last       = hold_last_reg;
        end else begin
            out_data.out_byte   = '0;
            out_data.out_valid  = 1'b0;
            out_data.stream_end = 1'b1;
            out_data.last       = 1'b1;
        end
    end

    sbr_out_reg u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (out_load),
        .load_data    (out_data),
        .free         (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_valid  (m_out_valid),
        .m_stream_end (m_stream_end),
        .m_last       (m_last)
    );

    // pending count tracks the number of marked slots
    a_pending_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == sbr_pkg::CNT_W'($countones(valid_reg)))
        else $error("pending count out of step with slot marks");

    // a new item is only taken with no byte in flight
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_reg)
        else $error("input taken while a drained byte is in flight");

    // ring reads only hit marked slots
    a_read_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> valid_reg[cur_slot])
        else $error("read of an unmarked ring slot");

    // end of stream is sticky
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("end of stream flag dropped");

    // no writes into the ring once the stream has ended
    a_no_write_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !ram_we)
        else $error("ring written after end of stream");

endmodule

// ===== sv/sbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sbr_out_reg.sv =====
// Output register of the result channel.
module sbr_out_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  sbr_pkg::result_t            load_data,
    output logic                        free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sbr_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_out_valid,
    output logic                        m_stream_end,
    output logic                        m_last
);

    logic             valid_reg;
    logic             valid_next;
    sbr_pkg::result_t data_reg;

    // free when empty or being taken this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = data_reg.out_byte;
    assign m_out_valid  = data_reg.out_valid;
    assign m_stream_end = data_reg.stream_end;
    assign m_last       = data_reg.last;

endmodule
